// ----- src/page_best_fit_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Page best-fit allocator assertion macros
// Shared property forms for the checker of the allocator ports.
// ----------------------------------------------------------------------------
`ifndef PAGE_BEST_FIT_ALLOCATOR_ASSERT_SVH
`define PAGE_BEST_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define PBFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, sampled on clk and held off during rst.
`define PBFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ----- src/pbfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Page best-fit allocator package
// Transaction types, command and status codes, and sizing constants.
// ----------------------------------------------------------------------------
package pbfa_pkg;

  localparam int DEF_MAX_PAGES = 64;
  localparam int PAGE_BYTES    = 4096;
  localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
  localparam int HEADER_BYTES  = 24;

  localparam logic [6:0] LIMIT_RESET = 7'd64;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  // Request transaction.
  typedef struct packed {
    logic        cmd;
    logic [17:0] request_bytes;
    logic [5:0]  free_page;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  chunk_page;
    logic [17:0] data_offset;
    logic [6:0]  heap_pages;
  } out_t;

endpackage

// ----- src/pbfa_cell.sv -----
// ----------------------------------------------------------------------------
// Page best-fit allocator page cell
// Holds the chunk state of one page and passes it on to its neighbor.
// ----------------------------------------------------------------------------
module pbfa_cell #(
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic             mark_in,
  input  logic             used_in,
  input  logic [CNT_W-1:0] cnt_in,
  output logic             mark,
  output logic             used,
  output logic [CNT_W-1:0] cnt
);

  // Flags clear on reset; the page count is undefined until written.
  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= 1'b0;
      used <= 1'b0;
    end else if (shift) begin
      mark <= mark_in;
      used <= used_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      cnt <= cnt_in;
    end
  end

endmodule

// ----- src/page_best_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// Page best-fit allocator
// Best-fit page heap with splitting and coalescing, kept in a ring of cells.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                 payload
//   in        input      in_valid / in_stall       pbfa_pkg::in_t
//   out       output     out_valid / out_stall     pbfa_pkg::out_t
//   cfg       input      cfg_write                 cfg_data (heap limit)
//
// For a transaction that changes the heap, the page ring rotates once to scan
// the chunks and once more to write the changes. A failed allocate or a bad
// free skips the write pass. No new request is taken until the result has
// been handed to the output register.
// Synchronous reset clears all chunks and the heap size; the limit is 64.
// The next request is taken while a result waits in the output register.
// A stalled result holds the block in its final state until it is taken.
module page_best_fit_allocator #(
  parameter int MAX_PAGES = pbfa_pkg::DEF_MAX_PAGES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  pbfa_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pbfa_pkg::out_t out_data,
  input  logic           cfg_write,
  input  logic [6:0]     cfg_data
);

  localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam int LW    = (CNT_W > 7) ? CNT_W : 7;
  localparam int EW    = LW + 1;
  localparam int PG_W  = 20;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_PAGES - 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PLAN, S_EDIT, S_DONE} state_t;

  // One change to apply to the page passing the ring head.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] pos;
    logic             mark_we;
    logic             mark;
    logic             used_we;
    logic             used;
    logic             cnt_we;
    logic [CNT_W-1:0] cnt;
  } edit_t;

  state_t state;

  // Ring of page cells.
  logic             c_mark [MAX_PAGES];
  logic             c_used [MAX_PAGES];
  logic [CNT_W-1:0] c_cnt  [MAX_PAGES];
  logic             wb_mark, wb_used;
  logic [CNT_W-1:0] wb_cnt;
  logic             shift;

  // Transaction and scan registers.
  logic             op;
  logic [PG_W-1:0]  pages;
  logic [5:0]       fp;
  logic             oversize;
  logic [IDX_W-1:0] pos;
  logic [CNT_W-1:0] heap_top;
  logic [6:0]       limit;
  logic             found;
  logic [IDX_W-1:0] best;
  logic [CNT_W-1:0] best_cnt;
  logic             prev_valid, prev_used;
  logic [IDX_W-1:0] prev;
  logic [CNT_W-1:0] prev_cnt;
  logic             fp_seen, fp_ok;
  logic [CNT_W-1:0] fp_cnt;
  logic [EW-1:0]    end_pos;
  logic             end_merge;
  logic [CNT_W-1:0] end_cnt;
  edit_t            ea, eb, ec;
  pbfa_pkg::out_t   res;

  // Plan values.
  edit_t            ea_next, eb_next, ec_next;
  pbfa_pkg::out_t   res_next;
  logic [CNT_W-1:0] heap_top_next;

  // Request sizing at the input.
  logic [PG_W-1:0]  req_sum, req_pages;
  logic [LW-1:0]    eff_limit;

  // Head view.
  logic             h_mark, h_used;
  logic [CNT_W-1:0] h_cnt;
  logic             in_heap, pos_is_fp, pos_lt_fp, pos_is_end;

  assign in_stall = (state != S_IDLE);
  assign shift    = (state == S_SCAN) || (state == S_EDIT);

  // Cell ring: each cell takes its upper neighbor, the last takes the head.
  for (genvar k = 0; k < MAX_PAGES; k++) begin : g_cell
    logic             nm, nu;
    logic [CNT_W-1:0] nc;
    if (k == MAX_PAGES - 1) begin : g_tail
      assign nm = wb_mark;
      assign nu = wb_used;
      assign nc = wb_cnt;
    end else begin : g_mid
      assign nm = c_mark[k+1];
      assign nu = c_used[k+1];
      assign nc = c_cnt[k+1];
    end
    pbfa_cell #(.CNT_W(CNT_W)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .mark_in (nm),
      .used_in (nu),
      .cnt_in  (nc),
      .mark    (c_mark[k]),
      .used    (c_used[k]),
      .cnt     (c_cnt[k])
    );
  end

  assign h_mark = c_mark[0];
  assign h_used = c_used[0];
  assign h_cnt  = c_cnt[0];

  assign in_heap    = CNT_W'(pos) < heap_top;
  assign pos_is_fp  = EW'(pos) == EW'(fp);
  assign pos_lt_fp  = EW'(pos) < EW'(fp);
  assign pos_is_end = fp_seen && (EW'(pos) == end_pos);

  // Write-back at the ring head applies the planned changes.
  always_comb begin
    wb_mark = h_mark;
    wb_used = h_used;
    wb_cnt  = h_cnt;
    if (state == S_EDIT) begin
      if (ea.en && ea.pos == pos) begin
        if (ea.mark_we) wb_mark = ea.mark;
        if (ea.used_we) wb_used = ea.used;
        if (ea.cnt_we)  wb_cnt  = ea.cnt;
      end
      if (eb.en && eb.pos == pos) begin
        if (eb.mark_we) wb_mark = eb.mark;
        if (eb.used_we) wb_used = eb.used;
        if (eb.cnt_we)  wb_cnt  = eb.cnt;
      end
      if (ec.en && ec.pos == pos) begin
        if (ec.mark_we) wb_mark = ec.mark;
        if (ec.used_we) wb_used = ec.used;
        if (ec.cnt_we)  wb_cnt  = ec.cnt;
      end
    end
  end

  // Page count of a request, with an empty request taking one page.
  always_comb begin
    req_sum   = PG_W'(in_data.request_bytes) + PG_W'(pbfa_pkg::HEADER_BYTES)
              + PG_W'(pbfa_pkg::PAGE_BYTES - 1);
    req_pages = req_sum >> pbfa_pkg::PAGE_SHIFT;
    if (req_pages == '0) req_pages = PG_W'(1);
    eff_limit = (LW'(limit) < LW'(MAX_PAGES)) ? LW'(limit) : LW'(MAX_PAGES);
  end

  // Plan the changes and the result from what the scan collected.
  always_comb begin
    logic             pm, trim, split, grow_fail;
    logic [IDX_W-1:0] start;
    logic [CNT_W-1:0] new_cnt;
    logic [CNT_W-1:0] pg;
    logic [31:0]      offs;

    ea_next       = '0;
    eb_next       = '0;
    ec_next       = '0;
    heap_top_next = heap_top;
    res_next      = '0;
    res_next.status = pbfa_pkg::STATUS_OK;
    pg        = CNT_W'(pages);
    pm        = prev_valid && !prev_used;
    start     = pm ? prev : IDX_W'(fp);
    new_cnt   = (pm ? prev_cnt : '0) + fp_cnt + (end_merge ? end_cnt : '0);
    trim      = (EW'(start) + EW'(new_cnt)) >= EW'(heap_top);
    split     = best_cnt > pg;
    grow_fail = oversize || ((EW'(heap_top) + EW'(pg)) > EW'(eff_limit))
             || (EW'(heap_top) >= EW'(MAX_PAGES));
    offs      = '0;

    if (op == pbfa_pkg::CMD_ALLOC) begin
      if (oversize) begin
        res_next.status = pbfa_pkg::STATUS_NO_SPACE;
      end else if (found) begin
        ea_next = '{en: 1'b1, pos: best, mark_we: 1'b0, mark: 1'b0,
                    used_we: 1'b1, used: 1'b1, cnt_we: split, cnt: pg};
        eb_next = '{en: split, pos: best + IDX_W'(pg), mark_we: 1'b1, mark: 1'b1,
                    used_we: 1'b1, used: 1'b0, cnt_we: 1'b1, cnt: best_cnt - pg};
        offs    = (32'(best) << pbfa_pkg::PAGE_SHIFT) + 32'(pbfa_pkg::HEADER_BYTES);
        res_next.chunk_page  = 6'(32'(best));
        res_next.data_offset = offs[17:0];
      end else if (grow_fail) begin
        res_next.status = pbfa_pkg::STATUS_NO_SPACE;
      end else begin
        ea_next = '{en: 1'b1, pos: IDX_W'(heap_top), mark_we: 1'b1, mark: 1'b1,
                    used_we: 1'b1, used: 1'b1, cnt_we: 1'b1, cnt: pg};
        heap_top_next = heap_top + pg;
        offs    = (32'(heap_top) << pbfa_pkg::PAGE_SHIFT) + 32'(pbfa_pkg::HEADER_BYTES);
        res_next.chunk_page  = 6'(32'(heap_top));
        res_next.data_offset = offs[17:0];
      end
    end else begin
      if (!fp_ok) begin
        res_next.status = pbfa_pkg::STATUS_BAD_FREE;
      end else begin
        ea_next = '{en: 1'b1, pos: start, mark_we: trim, mark: 1'b0,
                    used_we: 1'b1, used: 1'b0, cnt_we: 1'b1, cnt: new_cnt};
        eb_next = '{en: pm, pos: IDX_W'(fp), mark_we: 1'b1, mark: 1'b0,
                    used_we: 1'b1, used: 1'b0, cnt_we: 1'b0, cnt: '0};
        ec_next = '{en: end_merge, pos: IDX_W'(end_pos), mark_we: 1'b1, mark: 1'b0,
                    used_we: 1'b0, used: 1'b0, cnt_we: 1'b0, cnt: '0};
        if (trim) heap_top_next = CNT_W'(start);
      end
    end
    res_next.heap_pages = 7'(32'(heap_top_next));
  end

  // Sequencer: accept, scan pass, plan, edit pass, hand over the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      heap_top  <= '0;
      limit     <= pbfa_pkg::LIMIT_RESET;
      pos       <= '0;
    end else begin
      if (cfg_write) limit <= cfg_data;
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op         <= in_data.cmd;
            pages      <= req_pages;
            fp         <= in_data.free_page;
            oversize   <= req_pages > PG_W'(eff_limit);
            found      <= 1'b0;
            prev_valid <= 1'b0;
            fp_seen    <= 1'b0;
            fp_ok      <= 1'b0;
            end_merge  <= 1'b0;
            pos        <= '0;
            state      <= S_SCAN;
          end
        end

        S_SCAN: begin
          // Best fit: smallest free chunk that fits, earliest on ties.
          if (op == pbfa_pkg::CMD_ALLOC) begin
            if (h_mark && in_heap && !h_used && PG_W'(h_cnt) >= pages
                && (!found || h_cnt < best_cnt)) begin
              found    <= 1'b1;
              best     <= pos;
              best_cnt <= h_cnt;
            end
          end else begin
            // Nearest chunk below the freed one, the freed one, and its follower.
            if (h_mark && in_heap && pos_lt_fp) begin
              prev_valid <= 1'b1;
              prev       <= pos;
              prev_used  <= h_used;
              prev_cnt   <= h_cnt;
            end
            if (pos_is_fp) begin
              fp_seen <= 1'b1;
              fp_ok   <= h_mark && h_used && in_heap;
              fp_cnt  <= h_cnt;
              end_pos <= EW'(pos) + EW'(h_cnt);
            end
            if (pos_is_end) begin
              end_merge <= h_mark && !h_used && in_heap;
              end_cnt   <= h_cnt;
            end
          end
          if (pos == LAST_POS) begin
            pos   <= '0;
            state <= S_PLAN;
          end else begin
            pos <= pos + IDX_W'(1);
          end
        end

        S_PLAN: begin
          ea       <= ea_next;
          eb       <= eb_next;
          ec       <= ec_next;
          res      <= res_next;
          heap_top <= heap_top_next;
          state    <= ea_next.en ? S_EDIT : S_DONE;
        end

        S_EDIT: begin
          if (pos == LAST_POS) begin
            pos   <= '0;
            state <= S_DONE;
          end else begin
            pos <= pos + IDX_W'(1);
          end
        end

        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/pbfa_checker.sv -----
// ----------------------------------------------------------------------------
// Page best-fit allocator port checker
// Watches the allocator ports for ordering and result consistency.
// ----------------------------------------------------------------------------
`include "page_best_fit_allocator_assert.svh"

module pbfa_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input pbfa_pkg::out_t out_data
);

  // One transaction at a time: the block is busy right after an accept.
  `PBFA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // A stalled result stays in place.
  `PBFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Failed operations report no chunk.
  `PBFA_ASSERT_NOW(a_fail_no_chunk,
    out_valid && out_data.status != pbfa_pkg::STATUS_OK,
    out_data.chunk_page == 6'd0 && out_data.data_offset == 18'd0)

  // A stalled result stays valid while the busy flag changes.
  `PBFA_ASSERT_NEXT(a_no_overwrite, out_valid && out_stall && !$stable(in_stall),
    out_valid)

endmodule

bind page_best_fit_allocator pbfa_checker u_pbfa_checker (.*);

// ----- sim/tb_page_best_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// Page best-fit allocator testbench
// Drives allocate and free transactions with random idling and stalls, and
// checks every result against a behavioral model of the page heap.
// ----------------------------------------------------------------------------

// Behavioral heap model with a queue of expected results.
class heap_scoreboard;
  bit               start_mark [64];
  bit               in_use [64];
  int unsigned      page_count [64];
  int unsigned      heap_top;
  int unsigned      limit_pages;
  pbfa_pkg::out_t   pending [$];
  int               errors;

  function new();
    heap_top = 0;
    limit_pages = 64;
    errors = 0;
    for (int i = 0; i < 64; i++) begin
      start_mark[i] = 1'b0;
      in_use[i] = 1'b0;
      page_count[i] = 0;
    end
  endfunction

  function void set_limit(logic [6:0] v);
    limit_pages = 32'(v);
  endfunction

  function int unsigned lim();
    return (limit_pages < 64) ? limit_pages : 64;
  endfunction

  // Work out the result of one accepted request and queue it.
  function void note_request(pbfa_pkg::in_t t);
    pbfa_pkg::out_t r;
    r = '0;
    if (t.cmd == pbfa_pkg::CMD_ALLOC)
      r = allocate(t.request_bytes);
    else
      r = release_chunk(t.free_page);
    r.heap_pages = heap_top[6:0];
    pending.push_back(r);
  endfunction

  function pbfa_pkg::out_t allocate(logic [17:0] req);
    pbfa_pkg::out_t r;
    longint unsigned total;
    int unsigned need, p, best, best_cnt, cnt;
    bit found;
    r = '0;
    total = (64'(req) + 64'(pbfa_pkg::HEADER_BYTES) + 64'(pbfa_pkg::PAGE_BYTES) - 64'd1)
          / 64'(pbfa_pkg::PAGE_BYTES);
    need = 32'(total);
    if (need == 0) need = 1;
    found = 1'b0;
    best = 0;
    best_cnt = 0;
    if (need > lim()) begin
      r.status = pbfa_pkg::STATUS_NO_SPACE;
      return r;
    end
    // Walk the chunks for the smallest free one that fits.
    p = 0;
    while (p < heap_top && p < 64) begin
      cnt = page_count[p];
      if (cnt == 0) break;
      if (!in_use[p] && cnt >= need && (!found || cnt < best_cnt)) begin
        found = 1'b1;
        best = p;
        best_cnt = cnt;
      end
      p += cnt;
    end
    if (found) begin
      in_use[best] = 1'b1;
      if (best_cnt > need) begin
        page_count[best] = need;
        if (best + need < 64) begin
          start_mark[best + need] = 1'b1;
          in_use[best + need] = 1'b0;
          page_count[best + need] = best_cnt - need;
        end
      end
    end else begin
      if (heap_top + need > lim() || heap_top >= 64) begin
        r.status = pbfa_pkg::STATUS_NO_SPACE;
        return r;
      end
      best = heap_top;
      start_mark[best] = 1'b1;
      in_use[best] = 1'b1;
      page_count[best] = need;
      heap_top += need;
    end
    r.status = pbfa_pkg::STATUS_OK;
    r.chunk_page = best[5:0];
    r.data_offset = 18'(best * pbfa_pkg::PAGE_BYTES + pbfa_pkg::HEADER_BYTES);
    return r;
  endfunction

  function pbfa_pkg::out_t release_chunk(logic [5:0] fp);
    pbfa_pkg::out_t r;
    int unsigned q, prev, first, stop, f;
    bit has_prev;
    r = '0;
    f = 32'(fp);
    if (f >= heap_top || !start_mark[f] || !in_use[f]) begin
      r.status = pbfa_pkg::STATUS_BAD_FREE;
      return r;
    end
    q = 0;
    prev = 0;
    has_prev = 1'b0;
    while (q < f && q < 64 && page_count[q] != 0) begin
      prev = q;
      has_prev = 1'b1;
      q += page_count[q];
    end
    // Merge with a free chunk below, then with a free chunk above.
    first = f;
    if (has_prev && !in_use[prev]) begin
      page_count[prev] += page_count[f];
      start_mark[f] = 1'b0;
      in_use[f] = 1'b0;
      first = prev;
    end
    stop = first + page_count[first];
    if (stop < heap_top && stop < 64 && start_mark[stop] && !in_use[stop]) begin
      page_count[first] += page_count[stop];
      start_mark[stop] = 1'b0;
      stop = first + page_count[first];
    end
    in_use[first] = 1'b0;
    if (stop >= heap_top) begin
      start_mark[first] = 1'b0;
      heap_top = first;
    end
    r.status = pbfa_pkg::STATUS_OK;
    return r;
  endfunction

  // Compare one accepted result with the oldest expectation.
  function void check_result(pbfa_pkg::out_t got);
    pbfa_pkg::out_t e;
    if (pending.size() == 0) begin
      $error("unexpected result %p", got);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.status !== e.status) begin
      $error("status expected %0d actual %0d", e.status, got.status);
      errors++;
    end
    if (got.chunk_page !== e.chunk_page) begin
      $error("chunk_page expected %0d actual %0d", e.chunk_page, got.chunk_page);
      errors++;
    end
    if (got.data_offset !== e.data_offset) begin
      $error("data_offset expected %0d actual %0d", e.data_offset, got.data_offset);
      errors++;
    end
    if (got.heap_pages !== e.heap_pages) begin
      $error("heap_pages expected %0d actual %0d", e.heap_pages, got.heap_pages);
      errors++;
    end
  endfunction
endclass

module tb_page_best_fit_allocator;
  logic           clk = 0;
  logic           rst = 1;
  logic           in_valid = 0;
  logic           in_stall;
  pbfa_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 0;
  pbfa_pkg::out_t out_data;
  logic           cfg_write = 0;
  logic [6:0]     cfg_data = '0;

  heap_scoreboard sb = new();
  int  cycle_count = 0;
  bit  quiet_phase = 0;
  bit  hold_receiver = 0;
  bit  hold_started = 0;
  int  hold_left = 0;
  int  idle_left = 0;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int LATENCY = 140;

  page_best_fit_allocator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Accept and check results at the rising edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall)
      sb.check_result(out_data);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver stalls in random bursts, with one long hold-off on request.
  always @(negedge clk) begin
    if (hold_receiver && !hold_started) begin
      hold_started <= 1'b1;
      out_stall <= 1'b1;
      hold_left <= 3000;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (quiet_phase) begin
      out_stall <= 1'b0;
    end else if (idle_left > 0) begin
      idle_left <= idle_left - 1;
      out_stall <= (idle_left > 1);
    end else if ($urandom_range(0, 19) == 0) begin
      out_stall <= 1'b1;
      idle_left <= int'($urandom_range(1, 19));
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Send one request; hold it until accepted, with random idle bursts before.
  task automatic send(pbfa_pkg::in_t t);
    if (!quiet_phase && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 19)) @(negedge clk);
    in_data <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(t);
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic do_alloc(logic [17:0] bytes);
    pbfa_pkg::in_t t;
    t = '0;
    t.cmd = pbfa_pkg::CMD_ALLOC;
    t.request_bytes = bytes;
    t.free_page = 6'($urandom);
    send(t);
  endtask

  task automatic do_free(logic [5:0] pg);
    pbfa_pkg::in_t t;
    t = '0;
    t.cmd = pbfa_pkg::CMD_FREE;
    t.free_page = pg;
    t.request_bytes = 18'($urandom);
    send(t);
  endtask

  // Wait until all results are in, then let the block settle.
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_limit(logic [6:0] v);
    drain();
    cfg_data <= v;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_limit(v);
  endtask

  // Pick a free target: mostly a used chunk start, sometimes any page.
  function automatic logic [5:0] pick_free();
    int unsigned starts [$];
    for (int i = 0; i < 64; i++)
      if (sb.start_mark[i] && sb.in_use[i] && 32'(i) < sb.heap_top)
        starts.push_back(32'(i));
    if (starts.size() == 0 || $urandom_range(0, 9) == 0)
      return 6'($urandom);
    return 6'(starts[$urandom_range(0, starts.size() - 1)]);
  endfunction

  function automatic logic [17:0] pick_bytes();
    case ($urandom_range(0, 9))
      0: return 18'($urandom);
      1: return 18'(pbfa_pkg::PAGE_BYTES - pbfa_pkg::HEADER_BYTES);
      2: return 18'($urandom_range(0, 3 * pbfa_pkg::PAGE_BYTES));
      default: return 18'($urandom_range(0, pbfa_pkg::PAGE_BYTES));
    endcase
  endfunction

  initial begin
    int limits [5] = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd20};
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: extremes, zero-size request, bad frees, oversized request.
    do_alloc(18'd0);
    do_alloc(18'h3FFFF);
    do_alloc(18'(pbfa_pkg::PAGE_BYTES - pbfa_pkg::HEADER_BYTES));
    do_alloc(18'(pbfa_pkg::PAGE_BYTES - pbfa_pkg::HEADER_BYTES + 1));
    do_free(6'd0);
    do_free(6'd0);
    do_free(6'd63);
    do_free(6'd2);
    do_alloc(18'd100);
    do_free(6'd1);
    do_alloc(18'd5000);
    do_alloc(18'd200);
    do_free(6'd4);
    do_alloc(18'h3FFFF);
    for (int i = 0; i < 8; i++) do_free(6'(i));

    // Random phases with several limits, ending with the reset value.
    foreach (limits[k]) begin
      write_limit(7'(limits[k]));
      if (k == 1) hold_receiver = 1'b1;
      for (int n = 0; n < 380; n++) begin
        if ($urandom_range(0, 9) < 5) do_alloc(pick_bytes());
        else do_free(pick_free());
      end
    end
    quiet_phase = 1;
    write_limit(7'd64);
    for (int n = 0; n < 150; n++) begin
      if ($urandom_range(0, 1)) do_alloc(pick_bytes());
      else do_free(pick_free());
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+src
src/pbfa_pkg.sv
src/pbfa_cell.sv
src/page_best_fit_allocator.sv
src/pbfa_checker.sv
sim/tb_page_best_fit_allocator.sv
